/* rtl/core/hsfd_pkg.sv */
// Shared types, constants and the CRC-8 byte update for the humidity sensor
// frame decoder. No dependencies.
`default_nettype none
package hsfd_pkg;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    localparam logic [2:0] POS_FIRST_HIGH  = 3'd0;
    localparam logic [2:0] POS_FIRST_LOW   = 3'd1;
    localparam logic [2:0] POS_FIRST_CRC   = 3'd2;
    localparam logic [2:0] POS_SECOND_HIGH = 3'd3;
    localparam logic [2:0] POS_SECOND_LOW  = 3'd4;
    localparam logic [2:0] POS_SECOND_CRC  = 3'd5;

    localparam logic FRAME_MEASURE = 1'b0;
    localparam logic FRAME_STATUS  = 1'b1;

    localparam logic CODE_GOOD    = 1'b0;
    localparam logic CODE_CRC_ERR = 1'b1;

    typedef struct packed {
        logic        emit;
        logic        code;
        logic        status;
        logic [15:0] first_word;
        logic [15:0] second_word;
    } frame_result_t;

    typedef struct packed {
        logic               code;
        logic [15:0]        first_word;
        logic [15:0]        second_word;
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
    } result_item_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/hsfd_frame_tracker.sv */
// Frame position tracking, running CRC-8 check and raw word capture.
// Depends on hsfd_pkg.
`default_nettype none
module hsfd_frame_tracker (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    advance,
    input  wire [7:0]              rx_byte,
    input  wire                    frame_start,
    input  wire                    frame_kind,
    output hsfd_pkg::frame_result_t frame_res
);
    import hsfd_pkg::*;

    logic [2:0]  byte_position_reg, byte_position_next;
    logic [7:0]  running_crc_reg, running_crc_next;
    logic [7:0]  high_byte_hold_reg, high_byte_hold_next;
    logic [15:0] first_word_hold_reg, first_word_hold_next;
    logic [15:0] second_word_hold_reg, second_word_hold_next;
    logic        crc_failed_reg, crc_failed_next;

    logic [2:0]  pos;
    logic [7:0]  crc_base;
    logic        failed_base;
    logic        fail;
    logic        emit;
    logic        status;

    always_comb
    begin
        pos         = frame_start ? POS_FIRST_HIGH : byte_position_reg;
        if (pos > POS_SECOND_CRC)
        begin
            pos = POS_FIRST_HIGH;
        end
        crc_base    = frame_start ? CRC_INIT : running_crc_reg;
        failed_base = frame_start ? 1'b0 : crc_failed_reg;

        running_crc_next      = crc_base;
        high_byte_hold_next   = high_byte_hold_reg;
        first_word_hold_next  = first_word_hold_reg;
        second_word_hold_next = second_word_hold_reg;
        fail                  = failed_base;
        emit                  = 1'b0;
        status                = 1'b0;

        case (pos)
            POS_FIRST_HIGH, POS_SECOND_HIGH:
            begin
                running_crc_next    = crc8_byte(CRC_INIT, rx_byte);
                high_byte_hold_next = rx_byte;
            end
            POS_FIRST_LOW:
            begin
                running_crc_next     = crc8_byte(crc_base, rx_byte);
                first_word_hold_next = {high_byte_hold_reg, rx_byte};
            end
            POS_SECOND_LOW:
            begin
                running_crc_next      = crc8_byte(crc_base, rx_byte);
                second_word_hold_next = {high_byte_hold_reg, rx_byte};
            end
            default:
            begin
                fail             = failed_base | (crc_base != rx_byte);
                running_crc_next = CRC_INIT;
                if (pos == POS_FIRST_CRC && frame_kind == FRAME_STATUS)
                begin
                    emit   = 1'b1;
                    status = 1'b1;
                end
                else if (pos == POS_SECOND_CRC)
                begin
                    emit = 1'b1;
                end
            end
        endcase

        if (emit)
        begin
            byte_position_next = POS_FIRST_HIGH;
            running_crc_next   = CRC_INIT;
            crc_failed_next    = 1'b0;
        end
        else
        begin
            byte_position_next = pos + 3'd1;
            crc_failed_next    = fail;
        end
    end

    always_comb
    begin
        frame_res.emit        = emit;
        frame_res.code        = fail ? CODE_CRC_ERR : CODE_GOOD;
        frame_res.status      = status;
        frame_res.first_word  = first_word_hold_reg;
        frame_res.second_word = second_word_hold_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg    <= POS_FIRST_HIGH;
            running_crc_reg      <= CRC_INIT;
            high_byte_hold_reg   <= 8'd0;
            first_word_hold_reg  <= 16'd0;
            second_word_hold_reg <= 16'd0;
            crc_failed_reg       <= 1'b0;
        end
        else if (advance)
        begin
            byte_position_reg    <= byte_position_next;
            running_crc_reg      <= running_crc_next;
            high_byte_hold_reg   <= high_byte_hold_next;
            first_word_hold_reg  <= first_word_hold_next;
            second_word_hold_reg <= second_word_hold_next;
            crc_failed_reg       <= crc_failed_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/hsfd_converter.sv */
// Rounded fixed-point conversion of the raw words to hundredths of a degree
// and of a percent; masks fields by CRC status and frame kind. Depends on hsfd_pkg.
`default_nettype none
module hsfd_converter (
    input  hsfd_pkg::frame_result_t frame_res,
    output hsfd_pkg::result_item_t  item
);
    import hsfd_pkg::*;

    localparam logic [15:0] T_SCALE  = 16'd35000;
    localparam logic [15:0] H_SCALE  = 16'd20000;
    localparam logic [31:0] ROUND    = 32'd65535;
    localparam logic signed [15:0] T_OFFSET = 16'sd4500;

    logic [31:0] t_num, h_num;
    logic [32:0] t_adj, h_adj;
    logic [15:0] t_q, h_q;
    logic signed [15:0] t_signed;

    // floor(n / 131070) as ((n + (n >> 16) + 1) >> 17) for n below 2^32
    always_comb
    begin
        t_num    = frame_res.first_word * T_SCALE + ROUND;
        h_num    = frame_res.second_word * H_SCALE + ROUND;
        t_adj    = {1'b0, t_num} + {17'd0, t_num[31:16]} + 33'd1;
        h_adj    = {1'b0, h_num} + {17'd0, h_num[31:16]} + 33'd1;
        t_q      = t_adj[32:17];
        h_q      = h_adj[32:17];
        t_signed = $signed(t_q) - T_OFFSET;

        item = '0;
        if (frame_res.code == CODE_CRC_ERR)
        begin
            item.code = CODE_CRC_ERR;
        end
        else if (frame_res.status)
        begin
            item.first_word = frame_res.first_word;
        end
        else
        begin
            item.first_word        = frame_res.first_word;
            item.second_word       = frame_res.second_word;
            item.temperature_centi = t_signed[14:0];
            item.humidity_centi    = h_q[13:0];
        end
    end

endmodule
`default_nettype wire

/* rtl/core/humidity_sensor_frame_decoder_core.sv */
// Top level of the humidity sensor frame decoder: input register, frame
// tracker, converter and result register. Depends on hsfd_pkg and submodules.
//
// One byte per item enters an input register; in the next cycle the frame
// tracker checks the CRC-8 and the converter scales the raw words, and a
// frame's last byte loads the result register. Throughput is one item per
// cycle while input is not stalled, set by the single register-to-register
// pass. A held result stalls input only when the next pending byte would
// itself produce a result. frame_kind is sampled at the third byte of each
// frame and must be written while idle.
`default_nettype none
module humidity_sensor_frame_decoder_core (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_wen,
    input  wire         cfg_wdata,      // frame_kind
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // rx_byte[7:0]
    input  wire         s_axis_tuser,   // frame_start
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // first_word[15:0], second_word[31:16],
                                        // temperature_centi[46:32],
                                        // humidity_centi[60:47], zero[63:61]
    output logic        m_axis_tuser    // result_code
);
    import hsfd_pkg::*;

    logic          frame_kind_reg;
    logic          in_valid_reg, in_valid_next;
    logic [7:0]    in_byte_reg;
    logic          in_start_reg;
    logic          out_valid_reg, out_valid_next;
    result_item_t  out_item_reg;

    frame_result_t frame_res;
    result_item_t  conv_item;
    logic          out_free;
    logic          fire;
    logic          s_accept;

    hsfd_frame_tracker u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (fire),
        .rx_byte     (in_byte_reg),
        .frame_start (in_start_reg),
        .frame_kind  (frame_kind_reg),
        .frame_res   (frame_res)
    );

    hsfd_converter u_converter (
        .frame_res (frame_res),
        .item      (conv_item)
    );

    always_comb
    begin
        out_free      = !out_valid_reg || m_axis_tready;
        fire          = in_valid_reg && (!frame_res.emit || out_free);
        s_axis_tready = !in_valid_reg || fire;
        s_accept      = s_axis_tvalid && s_axis_tready;

        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire && frame_res.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_kind_reg <= FRAME_MEASURE;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                frame_kind_reg <= cfg_wdata;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
        end
        if (fire && frame_res.emit)
        begin
            out_item_reg <= conv_item;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_item_reg.code;
    assign m_axis_tdata  = {3'd0,
                            out_item_reg.humidity_centi,
                            out_item_reg.temperature_centi,
                            out_item_reg.second_word,
                            out_item_reg.first_word};

endmodule
`default_nettype wire
